>>> rtl/svse_pkg.sv
// ----------------------------------------------------------------------------
// svse_pkg: shared constants for the volatility surface evaluator
// Holds fixed-point formats, pipeline depths, register codes and the
// reciprocal constants used by the exponential series.
// ----------------------------------------------------------------------------
package svse_pkg;

  // Fixed-point format of the surface values; the exponential constants use Q30.
  localparam int FRAC_BITS = 16;

  // Square-root unit: 42-bit radicand, two radicand bits per stage.
  localparam int SQ_RAD_W = 42;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_LAT = SQ_ROOT_W;

  // Divider: 35-bit dividend, one quotient bit per stage.
  localparam int DIV_DVD_W = 35;
  localparam int DIV_DSR_W = 21;
  localparam int DIV_LAT = DIV_DVD_W;

  // Register codes, in register-file order.
  localparam logic [2:0] REG_LONG = 3'd0;
  localparam logic [2:0] REG_SHORT = 3'd1;
  localparam logic [2:0] REG_SPEED = 3'd2;
  localparam logic [2:0] REG_SLOPE = 3'd3;
  localparam logic [2:0] REG_CURV = 3'd4;
  localparam logic [2:0] REG_SMOOTH = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;

  // Register reset values.
  localparam logic [18:0] RST_LONG = 19'd13107;
  localparam logic [18:0] RST_SHORT = 19'd16384;
  localparam logic [20:0] RST_SPEED = 21'd65536;
  localparam logic signed [18:0] RST_SLOPE = -19'sd6554;
  localparam logic [18:0] RST_CURV = 19'd32768;
  localparam logic [16:0] RST_SMOOTH = 17'd6554;
  localparam logic [18:0] RST_FLOOR = 19'd655;

  // Exponential constants, Q30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam int TAY_TERMS = 12;
  localparam int TAY_ST = 2 * TAY_TERMS;

  // ceil(2^34 / k): exact floor division by k for any dividend below 2^30.
  localparam int TAY_SHIFT = 34;
  localparam logic [34:0] TAY_MAGIC [1:TAY_TERMS] = '{
    35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
    35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
    35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766
  };

  // Top of the output range.
  localparam logic [20:0] VOL_TOP = 21'd1048576;

endpackage

>>> rtl/svse_isqrt.sv
// ----------------------------------------------------------------------------
// svse_isqrt: pipelined integer square root
// Restoring digit-by-digit root, two radicand bits per stage, floor result.
// ----------------------------------------------------------------------------
module svse_isqrt
  import svse_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQ_RAD_W-1:0]  rad,
  output logic [SQ_ROOT_W-1:0] root
);

  logic [SQ_ROOT_W+2:0] rem_r [SQ_LAT];
  logic [SQ_ROOT_W-1:0] q_r [SQ_LAT];
  logic [SQ_RAD_W-1:0]  rad_r [SQ_LAT];

  logic [SQ_ROOT_W+2:0] rem_nxt [SQ_LAT];
  logic [SQ_ROOT_W-1:0] q_nxt [SQ_LAT];
  logic [SQ_RAD_W-1:0]  rad_nxt [SQ_LAT];

  // One root bit per stage from the stage before it.
  always_comb begin
    logic [SQ_ROOT_W+2:0] prem;
    logic [SQ_ROOT_W-1:0] pq;
    logic [SQ_RAD_W-1:0]  prad;
    logic [SQ_ROOT_W+2:0] sh;
    logic [SQ_ROOT_W+2:0] trial;
    for (int s = 0; s < SQ_LAT; s++) begin
      if (s == 0) begin
        prem = '0;
        pq = '0;
        prad = rad;
      end else begin
        prem = rem_r[s-1];
        pq = q_r[s-1];
        prad = rad_r[s-1];
      end
      sh = {prem[SQ_ROOT_W:0], prad[SQ_RAD_W-1 -: 2]};
      trial = {1'b0, pq, 2'b01};
      if (sh >= trial) begin
        rem_nxt[s] = sh - trial;
        q_nxt[s] = {pq[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = sh;
        q_nxt[s] = {pq[SQ_ROOT_W-2:0], 1'b0};
      end
      rad_nxt[s] = {prad[SQ_RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_LAT; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s] <= q_nxt[s];
        rad_r[s] <= rad_nxt[s];
      end
    end
  end

  assign root = q_r[SQ_LAT-1];

endmodule

>>> rtl/svse_div.sv
// ----------------------------------------------------------------------------
// svse_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, quotient truncated.
// ----------------------------------------------------------------------------
module svse_div
  import svse_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_DVD_W-1:0] dvd,
  input  logic [DIV_DSR_W-1:0] dsr,
  output logic [DIV_DVD_W-1:0] quo
);

  logic [DIV_DSR_W-1:0] rem_r [DIV_LAT];
  logic [DIV_DVD_W-1:0] q_r [DIV_LAT];
  logic [DIV_DVD_W-1:0] dvd_r [DIV_LAT];
  logic [DIV_DSR_W-1:0] dsr_r [DIV_LAT];

  logic [DIV_DSR_W-1:0] rem_nxt [DIV_LAT];
  logic [DIV_DVD_W-1:0] q_nxt [DIV_LAT];
  logic [DIV_DVD_W-1:0] dvd_nxt [DIV_LAT];
  logic [DIV_DSR_W-1:0] dsr_nxt [DIV_LAT];

  // Shift in one dividend bit and try a subtract in every stage.
  always_comb begin
    logic [DIV_DSR_W-1:0] prem;
    logic [DIV_DVD_W-1:0] pq;
    logic [DIV_DVD_W-1:0] pdvd;
    logic [DIV_DSR_W-1:0] pdsr;
    logic [DIV_DSR_W:0]   sh;
    for (int s = 0; s < DIV_LAT; s++) begin
      if (s == 0) begin
        prem = '0;
        pq = '0;
        pdvd = dvd;
        pdsr = dsr;
      end else begin
        prem = rem_r[s-1];
        pq = q_r[s-1];
        pdvd = dvd_r[s-1];
        pdsr = dsr_r[s-1];
      end
      sh = {prem, pdvd[DIV_DVD_W-1]};
      if (sh >= {1'b0, pdsr}) begin
        rem_nxt[s] = DIV_DSR_W'(sh - {1'b0, pdsr});
        q_nxt[s] = {pq[DIV_DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = DIV_DSR_W'(sh);
        q_nxt[s] = {pq[DIV_DVD_W-2:0], 1'b0};
      end
      dvd_nxt[s] = {pdvd[DIV_DVD_W-2:0], 1'b0};
      dsr_nxt[s] = pdsr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s] <= q_nxt[s];
        dvd_r[s] <= dvd_nxt[s];
        dsr_r[s] <= dsr_nxt[s];
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];

endmodule

>>> rtl/skew_volatility_surface_eval_core.sv
// ----------------------------------------------------------------------------
// skew_volatility_surface_eval_core: implied-volatility surface point
// Pipeline: the input register loads at the accepting edge, 60 further
// pipeline stages follow, set by the square-root and divider chain, then the
// output register presents the beat on out_*.
// Throughput: one beat per cycle while the skid stage is empty.
// Reset clears every valid bit, including the output and skid flags, and
// loads the register defaults.
// ----------------------------------------------------------------------------
module skew_volatility_surface_eval_core
  import svse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [20:0] moneyness, [41:21] expiry_time
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [20:0] volatility
  output logic [1:0]  out_tuser,   // [0] floor_applied, [1] saturated
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Stage positions.
  localparam int P_IN = 1;
  localparam int P_RAD = 2;
  localparam int P_ROOT = P_RAD + SQ_LAT;
  localparam int P_QUO = P_ROOT + DIV_LAT;
  localparam int P_PROD = P_QUO + 1;
  localparam int P_SKEW = P_PROD + 1;
  localparam int P_SUM = P_SKEW + 1;
  localparam int P_U = 4;
  localparam int P_E = P_U + TAY_ST + 1;
  localparam int P_AP = P_E + 1;
  localparam int P_ATM = P_AP + 1;
  localparam int P_WP = P_ROOT + 1;
  localparam int P_WING = P_WP + 1;

  // Configuration registers.
  logic [18:0]        long_r, short_r, curv_r, floor_r;
  logic [20:0]        speed_r;
  logic signed [18:0] slope_r;
  logic [16:0]        smooth_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // Pipeline control.
  logic               en;
  logic [P_SUM:P_IN]  vld_r;

  // Payload registers.
  logic signed [20:0] m_r [P_IN:P_QUO];
  logic               tz_r [P_IN:P_QUO];
  logic [20:0]        t1_r;
  logic [41:0]        rad_h_r, rad_t_r;
  logic [22:0]        xc_r;
  logic [7:0]         yi_r;
  logic [15:0]        yf_r;
  logic [29:0]        tu_r [0:TAY_ST];
  logic [30:0]        tterm_r [0:TAY_ST];
  logic [31:0]        tsum_r [0:TAY_ST];
  logic [4:0]         ti_r [0:TAY_ST];
  logic               ezero_r [0:TAY_ST];
  logic [30:0]        tterm_nxt [1:TAY_ST];
  logic [31:0]        tsum_nxt [1:TAY_ST];
  logic [16:0]        e_r;
  logic signed [37:0] ap_r;
  logic signed [22:0] atm_r [P_ATM:P_SKEW];
  logic [39:0]        wp_r;
  logic [23:0]        wing_r [P_WING:P_SKEW];
  logic signed [48:0] sprod_r;
  logic signed [32:0] skew_r;
  logic signed [34:0] sum_r;

  // Unit outputs and stage logic.
  logic [SQ_ROOT_W-1:0] h_root, t_root;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_DSR_W-1:0] dsr;
  logic [DIV_DVD_W-1:0] dvd;
  logic [18:0]          slope_mag;
  logic signed [20:0]   in_m;
  logic [20:0]          in_t;
  logic [20:0]          am;
  logic [41:0]          sx_prod;
  logic [25:0]          x_raw;
  logic [53:0]          y_prod;
  logic [59:0]          u_prod;
  logic signed [27:0]   eff;
  logic signed [34:0]   fin_cmp;
  logic [20:0]          fin_vol;
  logic                 fin_flo, fin_sat;

  // Output register and skid stage.
  logic               out_valid_r, skid_valid_r;
  logic [20:0]        out_vol_r, skid_vol_r;
  logic [1:0]         out_flag_r, skid_flag_r;
  logic               push, out_fire;

  // Truncate a product toward zero after dropping the fraction bits.
  function automatic logic signed [63:0] shift_frac(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] q;
    begin
      mag = p[63] ? 64'(-p) : 64'(p);
      q = mag >> FRAC_BITS;
      shift_frac = p[63] ? -$signed(q) : $signed(q);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r <= RST_LONG;
      short_r <= RST_SHORT;
      speed_r <= RST_SPEED;
      slope_r <= RST_SLOPE;
      curv_r <= RST_CURV;
      smooth_r <= RST_SMOOTH;
      floor_r <= RST_FLOOR;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LONG:   long_r <= cfg_pwdata[18:0];
        REG_SHORT:  short_r <= cfg_pwdata[18:0];
        REG_SPEED:  speed_r <= cfg_pwdata[20:0];
        REG_SLOPE:  slope_r <= cfg_pwdata[18:0];
        REG_CURV:   curv_r <= cfg_pwdata[18:0];
        REG_SMOOTH: smooth_r <= cfg_pwdata[16:0];
        REG_FLOOR:  floor_r <= cfg_pwdata[18:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      REG_LONG:   cfg_prdata = {13'd0, long_r};
      REG_SHORT:  cfg_prdata = {13'd0, short_r};
      REG_SPEED:  cfg_prdata = {11'd0, speed_r};
      REG_SLOPE:  cfg_prdata = 32'(slope_r);
      REG_CURV:   cfg_prdata = {13'd0, curv_r};
      REG_SMOOTH: cfg_prdata = {15'd0, smooth_r};
      REG_FLOOR:  cfg_prdata = {13'd0, floor_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless the skid stage is full.
  // --------------------------------------------------------------------------
  assign en = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[P_SUM-1:P_IN], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Input stage, radicands and the delay lines for moneyness and zero time.
  // --------------------------------------------------------------------------
  assign in_m = in_tdata[20:0];
  assign in_t = in_tdata[41:21];
  assign am = m_r[P_IN][20] ? 21'(-m_r[P_IN]) : 21'(m_r[P_IN]);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[P_IN] <= in_m;
      tz_r[P_IN] <= (in_t == '0);
      t1_r <= in_t;
      for (int n = P_IN + 1; n <= P_QUO; n++) begin
        m_r[n] <= m_r[n-1];
        tz_r[n] <= tz_r[n-1];
      end
      rad_h_r <= 42'(am) * 42'(am) + 42'(smooth_r) * 42'(smooth_r);
      rad_t_r <= 42'({t1_r, FRAC_BITS'(0)});
    end
  end

  // --------------------------------------------------------------------------
  // Exponential decay of the at-the-money term.
  // --------------------------------------------------------------------------
  assign sx_prod = 42'(speed_r) * 42'(t1_r);
  assign x_raw = sx_prod[41:FRAC_BITS];
  assign y_prod = 54'(xc_r) * 54'(LOG2E_Q30);
  assign u_prod = 60'({yf_r, 14'd0}) * 60'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      // Decay exponent, capped at 64.
      xc_r <= (x_raw > 26'(23'd64 << FRAC_BITS)) ? (23'd64 << FRAC_BITS) : x_raw[22:0];
      // Split into integer and fraction of the base-2 exponent.
      yi_r <= y_prod[53:30+FRAC_BITS];
      yf_r <= y_prod[30+FRAC_BITS-1:30];
      // Fraction scaled by ln2, the series variable.
      tu_r[0] <= u_prod[59:30];
      tterm_r[0] <= Q30_ONE;
      tsum_r[0] <= {1'b0, Q30_ONE};
      ti_r[0] <= yi_r[4:0];
      ezero_r[0] <= (yi_r > 8'd30);
    end
  end

  // Series terms: odd steps multiply by u, even steps divide by the term index.
  always_comb begin
    logic [65:0] prod;
    int k;
    for (int s = 1; s <= TAY_ST; s++) begin
      k = (s + 1) >> 1;
      if (s % 2 == 1) begin
        prod = 66'(tterm_r[s-1]) * 66'(tu_r[s-1]);
        tterm_nxt[s] = 31'(prod >> 30);
        tsum_nxt[s] = tsum_r[s-1];
      end else begin
        prod = 66'(tterm_r[s-1]) * 66'(TAY_MAGIC[k]);
        tterm_nxt[s] = 31'(prod >> TAY_SHIFT);
        if (k % 2 == 1) begin
          tsum_nxt[s] = tsum_r[s-1] - 32'(tterm_nxt[s]);
        end else begin
          tsum_nxt[s] = tsum_r[s-1] + 32'(tterm_nxt[s]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= TAY_ST; s++) begin
        tu_r[s] <= tu_r[s-1];
        tterm_r[s] <= tterm_nxt[s];
        tsum_r[s] <= tsum_nxt[s];
        ti_r[s] <= ti_r[s-1];
        ezero_r[s] <= ezero_r[s-1];
      end
      // Scale by the integer power of two and drop to the output format.
      e_r <= ezero_r[TAY_ST] ? '0
           : 17'((tsum_r[TAY_ST] >> ti_r[TAY_ST]) >> (30 - FRAC_BITS));
      // Level blend between short-term and long-run values.
      ap_r <= ($signed({1'b0, short_r}) - $signed({1'b0, long_r}))
              * $signed({1'b0, e_r});
      atm_r[P_ATM] <= 23'($signed({1'b0, long_r}) + shift_frac(64'(ap_r)));
      for (int n = P_ATM + 1; n <= P_SKEW; n++) begin
        atm_r[n] <= atm_r[n-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square roots: hypot for the wing, sqrt of time for the skew.
  // --------------------------------------------------------------------------
  svse_isqrt u_sqrt_hyp (
    .clk  (clk),
    .en   (en),
    .rad  (rad_h_r),
    .root (h_root)
  );

  svse_isqrt u_sqrt_time (
    .clk  (clk),
    .en   (en),
    .rad  (rad_t_r),
    .root (t_root)
  );

  // Smoothed absolute wing term.
  always_ff @(posedge clk) begin
    if (en) begin
      wp_r <= 40'(curv_r) * 40'(h_root - 21'(smooth_r));
      wing_r[P_WING] <= wp_r[39:FRAC_BITS];
      for (int n = P_WING + 1; n <= P_SKEW; n++) begin
        wing_r[n] <= wing_r[n-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Skew slope scaled by one over root time.
  // --------------------------------------------------------------------------
  assign slope_mag = slope_r[18] ? 19'(-slope_r) : 19'(slope_r);
  assign dvd = {slope_mag, FRAC_BITS'(0)};
  assign dsr = (t_root == '0) ? DIV_DSR_W'(1) : t_root;

  svse_div u_div (
    .clk (clk),
    .en  (en),
    .dvd (dvd),
    .dsr (dsr),
    .quo (quo)
  );

  always_comb begin
    if (tz_r[P_QUO]) begin
      eff = 28'(slope_r);
    end else if (slope_r[18]) begin
      eff = -$signed({1'b0, quo[26:0]});
    end else begin
      eff = $signed({1'b0, quo[26:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sprod_r <= 49'(eff) * 49'(m_r[P_QUO]);
      skew_r <= 33'(shift_frac(64'(sprod_r)));
      sum_r <= 35'(atm_r[P_SKEW]) + 35'(skew_r) + $signed({11'd0, wing_r[P_SKEW]});
    end
  end

  // --------------------------------------------------------------------------
  // Floor, then clip at the top of the range.
  // --------------------------------------------------------------------------
  always_comb begin
    fin_flo = 1'b0;
    fin_sat = 1'b0;
    fin_cmp = sum_r;
    if (sum_r < $signed({16'd0, floor_r})) begin
      fin_cmp = $signed({16'd0, floor_r});
      fin_flo = 1'b1;
    end
    if (fin_cmp > $signed({14'd0, VOL_TOP})) begin
      fin_cmp = $signed({14'd0, VOL_TOP});
      fin_sat = 1'b1;
    end
    fin_vol = fin_cmp[20:0];
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage.
  // --------------------------------------------------------------------------
  assign push = en && vld_r[P_SUM];
  assign out_fire = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload moves with the valid bits above.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_vol_r <= skid_vol_r;
        out_flag_r <= skid_flag_r;
      end
    end else if (push) begin
      if (!out_valid_r || out_tready) begin
        out_vol_r <= fin_vol;
        out_flag_r <= {fin_sat, fin_flo};
      end else begin
        skid_vol_r <= fin_vol;
        skid_flag_r <= {fin_sat, fin_flo};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {3'd0, out_vol_r};
  assign out_tuser = out_flag_r;

endmodule

>>> sim/tb_skew_volatility_surface_eval_core.sv
// ----------------------------------------------------------------------------
// tb_skew_volatility_surface_eval_core: self-checking bench for the surface core
// Streams log-moneyness and expiry points through the core with random idle
// and stall gaps on both sides. A scoreboard predicts each volatility point
// from its own model of the surface and checks every result beat in order.
// Several register settings are applied between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_skew_volatility_surface_eval_core
  import svse_pkg::*;
();

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_POINTS = 1250;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [20:0] vol;
    logic        flo;
    logic        sat;
  } vol_point_t;

  // Surface predictor plus the queue of volatility points still owed.
  class vol_scoreboard;
    logic [31:0] regs [7];
    int unsigned widths [7] = '{19, 19, 21, 19, 19, 17, 19};
    vol_point_t  owed [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      regs[REG_LONG] = RST_LONG;
      regs[REG_SHORT] = RST_SHORT;
      regs[REG_SPEED] = RST_SPEED;
      regs[REG_SLOPE] = {13'd0, RST_SLOPE};
      regs[REG_CURV] = RST_CURV;
      regs[REG_SMOOTH] = RST_SMOOTH;
      regs[REG_FLOOR] = RST_FLOOR;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      if (idx != REG_NONE) begin
        regs[idx] = value & ((32'd1 << widths[idx]) - 32'd1);
      end
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Truncate toward zero when dropping the fraction bits.
    function longint drop_frac(longint p);
      if (p < 0) return -((-p) >>> FRAC_BITS);
      return p >>> FRAC_BITS;
    endfunction

    // 2^-y by integer shift and a truncated Taylor series in Q30.
    function longint unsigned decay(longint unsigned x);
      longint unsigned y, i, f, u, sum, term;
      if (x > (64'd64 << FRAC_BITS)) x = 64'd64 << FRAC_BITS;
      y = (x * 64'd1549082005) >> 30;
      i = y >> FRAC_BITS;
      f = y & ((64'd1 << FRAC_BITS) - 1);
      if (i > 30) return 0;
      u = ((f << (30 - FRAC_BITS)) * 64'd744261118) >> 30;
      sum = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * u) >> 30) / k;
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      return (sum >> i) >> (30 - FRAC_BITS);
    endfunction

    function void note_input(logic [20:0] m_raw, logic [20:0] t_raw);
      longint m, t, lvl_long, lvl_short, slope, curv, w, flr;
      longint e, atm, eff, s, mag, skew, am, h, wing, vol;
      vol_point_t p;
      m = {{43{m_raw[20]}}, m_raw};
      t = {43'd0, t_raw};
      lvl_long = regs[REG_LONG];
      lvl_short = regs[REG_SHORT];
      slope = {{45{regs[REG_SLOPE][18]}}, regs[REG_SLOPE][18:0]};
      curv = regs[REG_CURV];
      w = regs[REG_SMOOTH];
      flr = regs[REG_FLOOR];
      e = decay((longint'(regs[REG_SPEED]) * t) >> FRAC_BITS);
      atm = lvl_long + drop_frac((lvl_short - lvl_long) * e);
      // Zero expiry keeps the one-year slope unscaled.
      if (t == 0) begin
        eff = slope;
      end else begin
        s = root(t << FRAC_BITS);
        if (s == 0) s = 1;
        mag = (slope < 0) ? -slope : slope;
        eff = (mag << FRAC_BITS) / s;
        if (slope < 0) eff = -eff;
      end
      skew = drop_frac(eff * m);
      am = (m < 0) ? -m : m;
      h = root(am * am + w * w);
      wing = (curv * (h - w)) >>> FRAC_BITS;
      vol = atm + skew + wing;
      p.flo = 1'b0;
      p.sat = 1'b0;
      if (vol < flr) begin
        vol = flr;
        p.flo = 1'b1;
      end
      if (vol > 1048576) begin
        vol = 1048576;
        p.sat = 1'b1;
      end
      p.vol = vol[20:0];
      owed = {owed, p};
    endfunction

    function void check_result(logic [20:0] vol, logic flo, logic sat);
      vol_point_t p;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: vol=%0d", vol);
        return;
      end
      p = owed.pop_front();
      if (p.vol !== vol || p.flo !== flo || p.sat !== sat) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d: expected vol=%0d floor=%0b sat=%0b, got vol=%0d floor=%0b sat=%0b",
                   checked, p.vol, p.flo, p.sat, vol, flo, sat);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  vol_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned points_sent = 0;

  skew_volatility_surface_eval_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("skew_volatility_surface_eval_core: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ((cycles / 2000) % 3 == 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[20:0], out_tuser[0], out_tuser[1]);
    end
  end

  task automatic send_point(logic [20:0] m, logic [20:0] t, int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, t, m};
    do @(posedge clk); while (!in_tready);
    sb.note_input(m, t);
    points_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] lng, logic [31:0] shrt, logic [31:0] spd,
                           logic [31:0] slp, logic [31:0] crv, logic [31:0] smo,
                           logic [31:0] flr);
    write_reg(REG_LONG, lng);
    write_reg(REG_SHORT, shrt);
    write_reg(REG_SPEED, spd);
    write_reg(REG_SLOPE, slp);
    write_reg(REG_CURV, crv);
    write_reg(REG_SMOOTH, smo);
    write_reg(REG_FLOOR, flr);
    @(posedge clk);
  endtask

  // Mostly in-range points with short expiries, some raw full-width values.
  task automatic send_random_point();
    logic [20:0] m;
    logic [20:0] t;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) m = 21'($urandom_range(0, 1048576)) - 21'd524288;
    else m = 21'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) t = 21'd0;
    else if (r < 60) t = 21'($urandom_range(1, 65536));
    else if (r < 85) t = 21'($urandom_range(0, 1966080));
    else t = 21'($urandom);
    send_point(m, t, pick_gap());
  endtask

  task automatic random_phase(int unsigned count);
    for (int i = 0; i < count; i++) send_random_point();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points under the reset settings: field extremes and zero expiry.
    send_point(21'd0, 21'd0, 0);
    send_point(-21'sd524288, 21'd0, 0);
    send_point(21'd524288, 21'd0, 0);
    send_point(21'h100000, 21'd1, 0);
    send_point(21'h0FFFFF, 21'h1FFFFF, 2);
    send_point(21'd524288, 21'd1966080, 0);
    send_point(-21'sd524288, 21'd1966080, 0);
    send_point(21'd6554, 21'd65536, 0);
    send_point(-21'sd6554, 21'd16384, 1);
    send_point(21'd0, 21'd1, 0);
    drain();

    // Floor case: levels far below the floor and a strongly negative skew.
    write_all(32'd0, 32'd0, 32'd0, 32'h0004_0000, 32'd0, 32'd0, 32'd262144);
    send_point(21'd524288, 21'd0, 0);
    send_point(21'd0, 21'd0, 0);
    send_point(-21'sd524288, 21'd100, 0);
    drain();

    // Saturation case: high levels, slope and curvature, zero floor, out-of-list index ignored.
    write_all(32'd262144, 32'd262144, 32'd1048576, 32'd131072, 32'd262144,
              32'd65536, 32'd0);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_point(21'd524288, 21'd0, 0);
    send_point(-21'sd524288, 21'd1, 0);
    send_point(21'd0, 21'd1966080, 0);
    send_point(21'h100000, 21'h1FFFFF, 0);
    drain();

    // Random phases across several settings, extremes and raw register bits.
    random_phase(RANDOM_POINTS / 5);
    write_all(32'd13107, 32'd16384, 32'd65536, 32'h0007_E666, 32'd32768, 32'd6554,
              32'd655);
    random_phase(RANDOM_POINTS / 5);
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(RANDOM_POINTS / 10);
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(RANDOM_POINTS / 10);
    for (int ph = 0; ph < 4; ph++) begin
      write_all($urandom_range(0, 262144), $urandom_range(0, 262144),
                $urandom_range(0, 1048576), $urandom_range(0, 262144) - 131072,
                $urandom_range(0, 262144), $urandom_range(0, 65536),
                $urandom_range(0, 65536));
      random_phase(RANDOM_POINTS / 10);
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.owed.size() != 0) sb.errors += sb.owed.size();
    $display("Sent %0d surface points over 9 register settings; checked %0d results.",
             points_sent, sb.checked);
    $display("Covered zero expiry, floor, saturation and random back-pressure; errors %0d.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("skew_volatility_surface_eval_core: match");
    end else begin
      $display("skew_volatility_surface_eval_core: mismatch");
    end
    $finish;
  end

endmodule
